>>> src/first_fit_heap_allocator_core_assert.svh
// Assertion macros for the first-fit heap allocator core.
// Included by the modules that carry concurrent assertions; no other dependency.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ffha assertion failed");
`define FFHA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ffha assertion failed");
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop)
`define FFHA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> src/ffha_pkg.sv
// Shared types, constants, status and datapath operation codes of the heap allocator.
// No dependencies.
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 2;
    localparam int ADDR_W       = $clog2(HEAP_BYTES);
    localparam int WORD_W       = ADDR_W + 1;
    localparam int POS_W        = ADDR_W + 2;
    localparam int FIELD_W      = 12;
    localparam int STATUS_W     = 3;
    localparam int OP_W         = 4;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic [WORD_W-1:0]          t_mag;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [FIELD_W-1:0]         t_field;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic [OP_W-1:0]            t_op;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_BAD_SIZE     = 3'd1;
    localparam t_status ST_NO_SPACE     = 3'd2;
    localparam t_status ST_NOT_FOUND    = 3'd3;
    localparam t_status ST_ALREADY_FREE = 3'd4;

    localparam t_pos   POS_HEAP   = POS_W'(HEAP_BYTES);
    localparam t_pos   POS_HDR    = POS_W'(HEADER_BYTES);
    localparam t_field MAX_REQ    = FIELD_W'(HEAP_BYTES - HEADER_BYTES);
    localparam t_word  WORD_RESET = WORD_W'(-(HEAP_BYTES - HEADER_BYTES));

    localparam t_op OP_NONE    = 4'd0;
    localparam t_op OP_INIT    = 4'd1;
    localparam t_op OP_CAPTURE = 4'd2;
    localparam t_op OP_START   = 4'd3;
    localparam t_op OP_AWALK   = 4'd4;
    localparam t_op OP_AFIT    = 4'd5;
    localparam t_op OP_AHEAD   = 4'd6;
    localparam t_op OP_FWALK   = 4'd7;
    localparam t_op OP_FMERGE  = 4'd8;

    typedef struct packed {
        logic bad_alloc;
        logic is_free;
        logic fit;
        logic walk_end;
        logic split;
        logic hit;
        logic blk_alloc;
    } t_dp_stat;

    function automatic t_mag word_mag(input t_word w);
        t_mag m;
        m = w[WORD_W-1] ? t_mag'(-w) : t_mag'(w);
        return m;
    endfunction

    function automatic t_word neg_word(input t_pos m);
        t_pos n;
        n = ~m + t_pos'(1);
        return t_word'(n);
    endfunction

endpackage

`default_nettype wire

>>> src/ffha_ctrl.sv
// Request sequencer of the heap allocator: walks, fits, splits and merges.
// Depends on ffha_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_heap_allocator_core_assert.svh"

module ffha_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_out_free,
    input  ffha_pkg::t_dp_stat  i_stat,
    output ffha_pkg::t_op       o_op,
    output logic                o_in_ready,
    output logic                o_done
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_AWALK  = 4'd3;
    localparam logic [3:0] S_AFIT   = 4'd4;
    localparam logic [3:0] S_AHEAD  = 4'd5;
    localparam logic [3:0] S_FWALK  = 4'd6;
    localparam logic [3:0] S_FMERGE = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_op       = ffha_pkg::OP_NONE;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            S_INIT: begin
                o_op    = ffha_pkg::OP_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = ffha_pkg::OP_CAPTURE;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_op = ffha_pkg::OP_START;
                if (i_stat.bad_alloc) begin
                    n_state = S_DONE;
                end else if (i_stat.is_free) begin
                    n_state = S_FWALK;
                end else begin
                    n_state = S_AWALK;
                end
            end
            S_AWALK: begin
                o_op = ffha_pkg::OP_AWALK;
                if (i_stat.fit) begin
                    n_state = S_AFIT;
                end else if (i_stat.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_AFIT: begin
                o_op    = ffha_pkg::OP_AFIT;
                n_state = i_stat.split ? S_AHEAD : S_DONE;
            end
            S_AHEAD: begin
                o_op    = ffha_pkg::OP_AHEAD;
                n_state = S_DONE;
            end
            S_FWALK: begin
                o_op = ffha_pkg::OP_FWALK;
                if (i_stat.hit) begin
                    n_state = i_stat.blk_alloc ? S_FMERGE : S_DONE;
                end else if (i_stat.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_FMERGE: begin
                o_op    = ffha_pkg::OP_FMERGE;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    `FFHA_ASSERT(a_ready_done_excl, i_clk, i_rst_n, !(o_in_ready && o_done))
    `FFHA_ASSERT(a_capture_then_start, i_clk, i_rst_n, (r_state == S_IDLE && i_in_valid) |=> o_op == ffha_pkg::OP_START)
    `FFHA_ASSERT(a_done_then_ready, i_clk, i_rst_n, o_done |=> o_in_ready)

endmodule

`default_nettype wire

>>> src/ffha_dpath.sv
// Heap header memory, walk pointers and result registers of the heap allocator.
// Depends on ffha_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_heap_allocator_core_assert.svh"

module ffha_dpath (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ffha_pkg::t_op           i_op,
    input  wire                     i_cmd,
    input  ffha_pkg::t_field        i_req_size,
    input  ffha_pkg::t_field        i_block_offset,
    output ffha_pkg::t_dp_stat      o_stat,
    output ffha_pkg::t_status       o_status,
    output ffha_pkg::t_field        o_granted_offset,
    output ffha_pkg::t_field        o_granted_size
);

    ffha_pkg::t_word    r_heap [ffha_pkg::HEAP_BYTES];
    ffha_pkg::t_word    r_rdata;
    ffha_pkg::t_word    r_bdata;
    ffha_pkg::t_addr    r_at;
    ffha_pkg::t_addr    r_before;
    ffha_pkg::t_addr    r_base;
    ffha_pkg::t_pos     r_m;
    ffha_pkg::t_field   r_size;
    ffha_pkg::t_field   r_target;
    ffha_pkg::t_status  r_st;
    ffha_pkg::t_field   r_goff;
    ffha_pkg::t_field   r_gsz;
    logic               r_is_free;
    logic               r_has_before;
    logic               r_nxt_in;

    ffha_pkg::t_mag     mag_rd;
    ffha_pkg::t_pos     nxt_pos;
    ffha_pkg::t_pos     rem_pos;
    ffha_pkg::t_pos     rem_mag;
    ffha_pkg::t_pos     m_merge;
    ffha_pkg::t_pos     merge_sum;
    logic               walk_end;
    logic               rd_free;
    logic               fit;
    logic               split;
    logic               hit;
    logic               merged;
    logic               bad;
    logic               rd_en;
    ffha_pkg::t_addr    rd_addr;
    logic               wr_en;
    ffha_pkg::t_addr    wr_addr;
    ffha_pkg::t_word    wr_data;

    always_comb begin
        mag_rd    = ffha_pkg::word_mag(r_rdata);
        nxt_pos   = ffha_pkg::t_pos'(r_at) + ffha_pkg::t_pos'(mag_rd) + ffha_pkg::POS_HDR;
        walk_end  = nxt_pos >= ffha_pkg::POS_HEAP;
        rd_free   = r_rdata[ffha_pkg::WORD_W-1] || (r_rdata == '0);
        fit       = rd_free && (ffha_pkg::t_mag'(r_size) <= mag_rd);
        split     = ffha_pkg::t_pos'(mag_rd) > (ffha_pkg::t_pos'(r_size) + ffha_pkg::POS_HDR);
        rem_pos   = ffha_pkg::t_pos'(r_at) + ffha_pkg::POS_HDR + ffha_pkg::t_pos'(r_size);
        rem_mag   = ffha_pkg::t_pos'(mag_rd) - ffha_pkg::t_pos'(r_size) - ffha_pkg::POS_HDR;
        hit       = r_at == ffha_pkg::t_addr'(r_target);
        merged    = r_has_before && (r_bdata[ffha_pkg::WORD_W-1] || (r_bdata == '0));
        m_merge   = ffha_pkg::t_pos'(ffha_pkg::word_mag(r_bdata))
                    + ffha_pkg::t_pos'(mag_rd) + ffha_pkg::POS_HDR;
        merge_sum = r_m + ffha_pkg::t_pos'(mag_rd) + ffha_pkg::POS_HDR;
        bad       = (r_size == '0) || (r_size > ffha_pkg::MAX_REQ);
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_at;
        wr_en   = 1'b0;
        wr_addr = r_at;
        wr_data = ffha_pkg::WORD_RESET;
        case (i_op)
            ffha_pkg::OP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            ffha_pkg::OP_START: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ffha_pkg::OP_AWALK: begin
                rd_en   = !fit && !walk_end;
                rd_addr = nxt_pos[ffha_pkg::ADDR_W-1:0];
            end
            ffha_pkg::OP_AFIT: begin
                if (!split) begin
                    wr_en   = 1'b1;
                    wr_data = ffha_pkg::t_word'(mag_rd);
                end else begin
                    wr_en   = rem_pos < ffha_pkg::POS_HEAP;
                    wr_addr = rem_pos[ffha_pkg::ADDR_W-1:0];
                    wr_data = ffha_pkg::neg_word(rem_mag);
                end
            end
            ffha_pkg::OP_AHEAD: begin
                wr_en   = 1'b1;
                wr_data = ffha_pkg::t_word'(r_size);
            end
            ffha_pkg::OP_FWALK: begin
                rd_en   = (!hit || !rd_free) && !walk_end;
                rd_addr = nxt_pos[ffha_pkg::ADDR_W-1:0];
            end
            ffha_pkg::OP_FMERGE: begin
                wr_en   = 1'b1;
                wr_addr = r_base;
                wr_data = (r_nxt_in && rd_free) ? ffha_pkg::neg_word(merge_sum)
                                                : ffha_pkg::neg_word(r_m);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_heap[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            ffha_pkg::OP_CAPTURE: begin
                r_is_free <= i_cmd;
                r_size    <= i_req_size;
                r_target  <= i_block_offset;
                r_st      <= ffha_pkg::ST_OK;
                r_goff    <= '0;
                r_gsz     <= '0;
            end
            ffha_pkg::OP_START: begin
                r_at         <= '0;
                r_has_before <= 1'b0;
                if (!r_is_free && bad) begin
                    r_st <= ffha_pkg::ST_BAD_SIZE;
                end
            end
            ffha_pkg::OP_AWALK: begin
                if (!fit) begin
                    if (walk_end) begin
                        r_st <= ffha_pkg::ST_NO_SPACE;
                    end else begin
                        r_at <= nxt_pos[ffha_pkg::ADDR_W-1:0];
                    end
                end
            end
            ffha_pkg::OP_AFIT: begin
                r_goff <= ffha_pkg::t_field'(r_at);
                r_gsz  <= split ? r_size : ffha_pkg::t_field'(mag_rd);
            end
            ffha_pkg::OP_FWALK: begin
                if (hit) begin
                    if (rd_free) begin
                        r_st <= ffha_pkg::ST_ALREADY_FREE;
                    end else begin
                        r_base   <= merged ? r_before : r_at;
                        r_m      <= merged ? m_merge : ffha_pkg::t_pos'(mag_rd);
                        r_nxt_in <= !walk_end;
                    end
                end else if (walk_end) begin
                    r_st <= ffha_pkg::ST_NOT_FOUND;
                end else begin
                    r_before     <= r_at;
                    r_bdata      <= r_rdata;
                    r_has_before <= 1'b1;
                    r_at         <= nxt_pos[ffha_pkg::ADDR_W-1:0];
                end
            end
            default: begin
                r_at <= r_at;
            end
        endcase
    end

    always_comb begin
        o_stat.bad_alloc = !r_is_free && bad;
        o_stat.is_free   = r_is_free;
        o_stat.fit       = fit;
        o_stat.walk_end  = walk_end;
        o_stat.split     = split;
        o_stat.hit       = hit;
        o_stat.blk_alloc = !rd_free;
    end

    assign o_status         = r_st;
    assign o_granted_offset = r_goff;
    assign o_granted_size   = r_gsz;

    `FFHA_ASSERT_NR(a_no_rw_clash, i_clk, (wr_en && rd_en) |-> wr_addr != rd_addr)
    `FFHA_ASSERT(a_write_ok_only, i_clk, i_rst_n, (i_op == ffha_pkg::OP_AHEAD || i_op == ffha_pkg::OP_FMERGE) |-> r_st == ffha_pkg::ST_OK)
    `FFHA_ASSERT(a_awalk_is_alloc, i_clk, i_rst_n, (i_op == ffha_pkg::OP_AWALK) |-> !r_is_free)

endmodule

`default_nettype wire

>>> src/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: stream ports and output register.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
// One request at a time; the next is accepted in the cycle after the result is loaded
// into the output register. The walk reads one header per cycle.
// Reset: synchronous, active low; free header written first. Results wait in the output register.
`default_nettype none

module first_fit_heap_allocator_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,   // req_size [11:0], block_offset [23:12]
    input  wire  [0:0]  i_s_axis_tuser,   // cmd [0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // granted_offset [11:0], granted_size [23:12]
    output logic [2:0]  o_m_axis_tuser    // status [2:0]
);

    ffha_pkg::t_op      op;
    ffha_pkg::t_dp_stat stat;
    ffha_pkg::t_status  res_status;
    ffha_pkg::t_field   res_offset;
    ffha_pkg::t_field   res_size;
    logic               done;
    logic               out_free;

    logic               r_out_valid;
    ffha_pkg::t_status  r_out_status;
    ffha_pkg::t_field   r_out_offset;
    ffha_pkg::t_field   r_out_size;

    assign out_free = !r_out_valid || i_m_axis_tready;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_op       (op),
        .o_in_ready (o_s_axis_tready),
        .o_done     (done)
    );

    ffha_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_cmd            (i_s_axis_tuser[0]),
        .i_req_size       (i_s_axis_tdata[11:0]),
        .i_block_offset   (i_s_axis_tdata[23:12]),
        .o_stat           (stat),
        .o_status         (res_status),
        .o_granted_offset (res_offset),
        .o_granted_size   (res_size)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_status <= res_status;
            r_out_offset <= res_offset;
            r_out_size   <= res_size;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_size, r_out_offset};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire
